// ===== rtl/core/xorshift_permutation_generator_top_macros.svh =====
// ----------------------------------------------------------------------------
// xorshift_permutation_generator_top_macros.svh
// Assertion macros shared by the permutation generator RTL.
// ----------------------------------------------------------------------------
`ifndef XORSHIFT_PERMUTATION_GENERATOR_TOP_MACROS_SVH
`define XORSHIFT_PERMUTATION_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XPG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define XPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/xpg_pkg.sv =====
// ----------------------------------------------------------------------------
// xpg_pkg
// Shared types, constants and the xorshift32 step for the permutation
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package xpg_pkg;

  localparam int SEED_W   = 32;
  localparam int STEP_W   = $clog2(SEED_W);
  localparam int COUNT_W  = 5;
  localparam int FIELD_W  = 4;
  localparam int CFG_DW   = 8;
  localparam int OUT_DW   = 8;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd15;

  localparam int XS_SHL_A = 13;
  localparam int XS_SHR_B = 17;
  localparam int XS_SHL_C = 5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_ADVANCE,
    ST_DIVIDE,
    ST_READ,
    ST_SWAP_I,
    ST_SWAP_J,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } xpg_state_t;

  function automatic logic [SEED_W-1:0] xs32_next(input logic [SEED_W-1:0] v);
    logic [SEED_W-1:0] a;
    logic [SEED_W-1:0] b;
    a = v ^ (v << XS_SHL_A);
    b = a ^ (a >> XS_SHR_B);
    return b ^ (b << XS_SHL_C);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/xpg_modulo.sv =====
// ----------------------------------------------------------------------------
// xpg_modulo
// Bit-serial restoring remainder unit: 32-bit dividend modulo a narrow
// divisor, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module xpg_modulo #(
  parameter int DW = 5
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire [xpg_pkg::SEED_W-1:0] dividend,
  input  wire [DW-1:0]             divisor,
  output logic                     done,
  output logic [DW-1:0]            remainder
);
  import xpg_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [SEED_W-1:0]   x_r, x_nxt;
  logic [DW-1:0]       rem_r, rem_nxt;
  logic [DW-1:0]       div_r, div_nxt;
  logic [DW:0]         shifted;
  logic [DW:0]         diff;

  // Bring in the next dividend bit and subtract the divisor when it fits.
  assign shifted = {rem_r, x_r[SEED_W-1]};
  assign diff    = shifted - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      x_nxt    = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      x_nxt   = x_r << 1;
      rem_nxt = (shifted >= {1'b0, div_r}) ? diff[DW-1:0] : shifted[DW-1:0];
      cnt_nxt = cnt_r + STEP_W'(1);
      if (cnt_r == STEP_W'(SEED_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ===== rtl/core/xpg_table.sv =====
// ----------------------------------------------------------------------------
// xpg_table
// Order table: one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module xpg_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire          clk,
  input  wire          we,
  input  wire [AW-1:0] waddr,
  input  wire [AW-1:0] wdata,
  input  wire          re,
  input  wire [AW-1:0] raddr_a,
  input  wire [AW-1:0] raddr_b,
  output logic [AW-1:0] rdata_a,
  output logic [AW-1:0] rdata_b
);

  logic [AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/xorshift_permutation_generator_top.sv =====
// Per seed: the table is filled with 0..n-1, then each of the n-1 swaps takes
// one xorshift step, the bit-serial remainder unit, a table read and two table
// writes; each emitted entry takes a table read and a wait for out_tready.
// The remainder unit dominates the time per seed.
// Throughput: one seed at a time; in_tready is high only while idle.
// Reset (rst_n low, synchronous): idle, entry_count = 15, generator state 0.
// ----------------------------------------------------------------------------
// xorshift_permutation_generator_top
// Fisher-Yates shuffle of 0..n-1 driven by xorshift32, streamed out in order.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xorshift_permutation_generator_top_macros.svh"

module xorshift_permutation_generator_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  // Configuration: entry_count in [4:0].
  input  wire                        cfg_tvalid,
  output logic                       cfg_tready,
  input  wire [xpg_pkg::CFG_DW-1:0]  cfg_tdata,
  // Seed in [31:0].
  input  wire                        in_tvalid,
  output logic                       in_tready,
  input  wire [xpg_pkg::SEED_W-1:0]  in_tdata,
  // position in [3:0], entry_value in [7:4].
  output logic                       out_tvalid,
  input  wire                        out_tready,
  output logic [xpg_pkg::OUT_DW-1:0] out_tdata,
  output logic                       out_tlast
);
  import xpg_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  xpg_state_t          state_r, state_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [SEED_W-1:0]   gen_r, gen_nxt;
  logic [IW-1:0]       i_r, i_nxt;
  logic [IW-1:0]       j_r, j_nxt;
  logic [IW-1:0]       k_r, k_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [CW-1:0]       n_sat;
  logic                k_at_end;

  logic                tbl_we;
  logic [IW-1:0]       tbl_waddr;
  logic [IW-1:0]       tbl_wdata;
  logic                tbl_re;
  logic [IW-1:0]       tbl_raddr_a;
  logic [IW-1:0]       tbl_raddr_b;
  logic [IW-1:0]       tbl_rdata_a;
  logic [IW-1:0]       tbl_rdata_b;

  logic                div_start;
  logic                div_done;
  logic [CW-1:0]       div_rem;
  logic [SEED_W-1:0]   gen_step;

  logic                in_xfer;
  logic                out_xfer;

  assign n_sat    = (int'(count_r) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(count_r);
  assign k_at_end = (CW'(k_r) + CW'(1)) == n_r;
  assign gen_step = xs32_next(gen_r);
  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  xpg_table #(
    .DEPTH (MAX_ENTRIES),
    .AW    (IW)
  ) u_table (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (tbl_waddr),
    .wdata   (tbl_wdata),
    .re      (tbl_re),
    .raddr_a (tbl_raddr_a),
    .raddr_b (tbl_raddr_b),
    .rdata_a (tbl_rdata_a),
    .rdata_b (tbl_rdata_b)
  );

  xpg_modulo #(
    .DW (CW)
  ) u_modulo (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (gen_step),
    .divisor   (CW'(i_r) + CW'(1)),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (n_sat != '0)) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (k_at_end) begin
          state_nxt = (n_r == CW'(1)) ? ST_EMIT_RD : ST_ADVANCE;
        end
      end
      ST_ADVANCE: state_nxt = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:   state_nxt = ST_SWAP_I;
      ST_SWAP_I: state_nxt = ST_SWAP_J;
      ST_SWAP_J: state_nxt = (i_r == IW'(1)) ? ST_EMIT_RD : ST_ADVANCE;
      ST_EMIT_RD: state_nxt = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (out_tready) begin
          state_nxt = k_at_end ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    tbl_we      = 1'b0;
    tbl_waddr   = k_r;
    tbl_wdata   = k_r;
    tbl_re      = 1'b0;
    tbl_raddr_a = i_r;
    tbl_raddr_b = j_r;
    div_start   = 1'b0;
    unique case (state_r)
      ST_IDLE:    in_tready = 1'b1;
      ST_FILL:    tbl_we = 1'b1;
      ST_ADVANCE: div_start = 1'b1;
      ST_DIVIDE:  ;
      ST_READ:    tbl_re = 1'b1;
      ST_SWAP_I: begin
        tbl_we    = 1'b1;
        tbl_waddr = i_r;
        tbl_wdata = tbl_rdata_b;
      end
      ST_SWAP_J: begin
        // Read data still holds the entry at i from before the first write.
        tbl_we    = 1'b1;
        tbl_waddr = j_r;
        tbl_wdata = tbl_rdata_a;
      end
      ST_EMIT_RD: begin
        tbl_re      = 1'b1;
        tbl_raddr_a = k_r;
      end
      ST_EMIT_WAIT: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  // Datapath registers.
  always_comb begin
    count_nxt = count_r;
    gen_nxt   = gen_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    if (cfg_tvalid && cfg_tready) begin
      count_nxt = cfg_tdata[COUNT_W-1:0];
    end
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          gen_nxt = in_tdata;
          n_nxt   = n_sat;
          k_nxt   = '0;
          i_nxt   = '0;
        end
      end
      ST_FILL: begin
        if (k_at_end) begin
          k_nxt = '0;
          i_nxt = IW'(n_r - CW'(1));
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end
      ST_ADVANCE: gen_nxt = gen_step;
      ST_DIVIDE: begin
        if (div_done) begin
          j_nxt = div_rem[IW-1:0];
        end
      end
      ST_SWAP_J:  i_nxt = i_r - IW'(1);
      ST_EMIT_WAIT: begin
        if (out_tready && !k_at_end) begin
          k_nxt = k_r + IW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= COUNT_RESET;
      gen_r   <= '0;
      i_r     <= '0;
      k_r     <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      gen_r   <= gen_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      n_r     <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r <= j_nxt;
  end

  assign cfg_tready = 1'b1;
  assign out_tdata  = {FIELD_W'(tbl_rdata_a), FIELD_W'(k_r)};
  assign out_tlast  = k_at_end;

  `XPG_ASSERT_IMPL(a_ready_excl, clk, rst_n, in_tready, !out_tvalid, "input ready while result pending")
  `XPG_ASSERT_NEXT(a_last_to_idle, clk, rst_n, out_xfer && out_tlast, in_tready, "not idle after last transfer")
  `XPG_ASSERT_IMPL(a_waddr_range, clk, rst_n, tbl_we, CW'(tbl_waddr) < n_r, "table write beyond entry count")
  `XPG_ASSERT_NEXT(a_start_div, clk, rst_n, div_start, state_r == ST_DIVIDE && !div_done, "remainder unit not running after start")

endmodule

`default_nettype wire

// ===== tb/shuffle_checker.sv =====
// ----------------------------------------------------------------------------
// shuffle_checker
// Watches the configuration, seed and result channels of the permutation
// generator. It predicts the shuffled order for every accepted seed and
// compares each result transfer field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module shuffle_checker #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_tvalid,
  input  wire                        cfg_tready,
  input  wire [xpg_pkg::CFG_DW-1:0]  cfg_tdata,
  input  wire                        in_tvalid,
  input  wire                        in_tready,
  input  wire [xpg_pkg::SEED_W-1:0]  in_tdata,
  input  wire                        out_tvalid,
  input  wire                        out_tready,
  input  wire [xpg_pkg::OUT_DW-1:0]  out_tdata,
  input  wire                        out_tlast,
  output int                         mismatches,
  output int                         outstanding,
  output int                         entries_checked
);

  typedef struct packed {
    logic [xpg_pkg::FIELD_W-1:0] position;
    logic [xpg_pkg::FIELD_W-1:0] entry_value;
    logic                        last;
  } perm_entry_t;

  perm_entry_t                  expected_entries[$];
  logic [xpg_pkg::COUNT_W-1:0]  entry_count;
  int                           fail_total;
  int                           checked_total;

  // Fisher-Yates over the identity order, stepping xorshift32 once per swap.
  task automatic predict_shuffle(input logic [xpg_pkg::SEED_W-1:0] seed);
    logic [xpg_pkg::FIELD_W-1:0] order [MAX_ENTRIES];
    logic [xpg_pkg::FIELD_W-1:0] held;
    logic [31:0]                 x;
    perm_entry_t                 e;
    int                          n;
    int                          i;
    int                          j;
    n = (int'(entry_count) > MAX_ENTRIES) ? MAX_ENTRIES : int'(entry_count);
    x = seed;
    for (i = 0; i < n; i++) order[i] = i[xpg_pkg::FIELD_W-1:0];
    for (i = n - 1; i > 0; i--) begin
      x = x ^ (x << 13);
      x = x ^ (x >> 17);
      x = x ^ (x << 5);
      j = int'(x % 32'(i + 1));
      held     = order[i];
      order[i] = order[j];
      order[j] = held;
    end
    for (i = 0; i < n; i++) begin
      e.position    = i[xpg_pkg::FIELD_W-1:0];
      e.entry_value = order[i];
      e.last        = (i == n - 1);
      expected_entries.push_back(e);
    end
  endtask

  task automatic note_failure(input string what);
    fail_total++;
    if (fail_total <= 10) $display("[%0t] checker: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    perm_entry_t want;
    logic [xpg_pkg::FIELD_W-1:0] got_pos;
    logic [xpg_pkg::FIELD_W-1:0] got_val;
    if (!rst_n) begin
      entry_count   = xpg_pkg::COUNT_RESET;
      fail_total    = 0;
      checked_total = 0;
      expected_entries.delete();
    end else begin
      got_pos = out_tdata[xpg_pkg::FIELD_W-1:0];
      got_val = out_tdata[2*xpg_pkg::FIELD_W-1:xpg_pkg::FIELD_W];
      if (out_tvalid && out_tready) begin
        if (expected_entries.size() == 0) begin
          note_failure($sformatf("unexpected result transfer pos %0d val %0d last %0b",
                                 got_pos, got_val, out_tlast));
        end else begin
          want = expected_entries.pop_front();
          checked_total++;
          if (got_pos !== want.position || got_val !== want.entry_value ||
              out_tlast !== want.last) begin
            note_failure($sformatf({"result mismatch: expected pos %0d val %0d last %0b, ",
                                    "got pos %0d val %0d last %0b"},
                                   want.position, want.entry_value, want.last,
                                   got_pos, got_val, out_tlast));
          end
        end
      end
      // A seed taken at the same edge as a count write still sees the old count.
      if (in_tvalid && in_tready) predict_shuffle(in_tdata);
      if (cfg_tvalid && cfg_tready) entry_count = cfg_tdata[xpg_pkg::COUNT_W-1:0];
    end
    // Published with nonblocking updates so the stimulus side reads settled values.
    mismatches      <= fail_total;
    outstanding     <= expected_entries.size();
    entries_checked <= checked_total;
  end

endmodule

// ===== tb/tb_xorshift_permutation_generator_top.sv =====
// ----------------------------------------------------------------------------
// tb_xorshift_permutation_generator_top
// Drives seeds and entry counts into the permutation generator with random
// gaps and output stalls; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_xorshift_permutation_generator_top;

  localparam int TOTAL_SEEDS  = 430;
  localparam int SETTLE       = 80;
  localparam int CYCLE_LIMIT  = 3000000;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_tvalid = 1'b0;
  logic                        cfg_tready;
  logic [xpg_pkg::CFG_DW-1:0]  cfg_tdata = '0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [xpg_pkg::SEED_W-1:0]  in_tdata = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [xpg_pkg::OUT_DW-1:0]  out_tdata;
  logic                        out_tlast;

  int          mismatches;
  int          outstanding;
  int          entries_checked;
  int          seeds_sent = 0;
  int          cycles = 0;
  int          gap_level = 0;
  int          ready_level = 0;
  int          ready_hold = 0;
  logic [31:0] counts_seen = 32'h0000_8000;

  xorshift_permutation_generator_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  shuffle_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_tvalid      (cfg_tvalid),
    .cfg_tready      (cfg_tready),
    .cfg_tdata       (cfg_tdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .entries_checked (entries_checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d entries outstanding", cycles, outstanding);
      $display("xorshift_permutation_generator_top regression: fail");
      $finish;
    end
  end

  // Level 0 never idles; higher levels give mostly short idles and a few long ones.
  function automatic int idle_length(input int level);
    int r;
    r = $urandom_range(0, 99);
    if (level == 0) return 0;
    if (level == 1) begin
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
    end
    if (r < 30) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_tready <= 1'b1;
      ready_hold <= idle_length(ready_level);
    end
  end

  function automatic logic [31:0] random_seed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 32'h0000_0000;
    if (r < 12) return 32'hFFFF_FFFF;
    if (r < 20) return 32'h1 << $urandom_range(0, 31);
    return $urandom;
  endfunction

  // Valid stays high across back-to-back transfers; it drops only before a gap or when draining.
  task automatic send_seed(input logic [xpg_pkg::SEED_W-1:0] seed);
    int gap;
    gap = idle_length(gap_level);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= seed;
    do @(posedge clk); while (!in_tready);
    seeds_sent++;
  endtask

  // A zero count yields no results, so the settle time also covers a busy block.
  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(input logic [xpg_pkg::COUNT_W-1:0] count);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= {3'($urandom), count};
    do @(posedge clk); while (!cfg_tready);
    cfg_tvalid <= 1'b0;
    counts_seen[count] = 1'b1;
  endtask

  initial begin
    int phase_items;
    int r;
    logic [xpg_pkg::COUNT_W-1:0] count;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: reset count first, then one, zero, full, saturated and two.
    send_seed(32'h0000_0000);
    send_seed(32'hFFFF_FFFF);
    send_seed(32'h0000_0001);
    send_seed(32'h8000_0000);
    drain_and_settle();
    write_count(5'd1);
    send_seed($urandom);
    send_seed(32'h0000_0000);
    drain_and_settle();
    write_count(5'd0);
    send_seed(32'h1234_5678);
    send_seed(32'hFFFF_FFFF);
    drain_and_settle();
    write_count(5'd16);
    send_seed(32'h0000_0000);
    send_seed(32'hFFFF_FFFF);
    send_seed($urandom);
    drain_and_settle();
    write_count(5'd31);
    send_seed(32'h0000_0001);
    send_seed($urandom);
    drain_and_settle();
    write_count(5'd17);
    send_seed($urandom);
    drain_and_settle();
    write_count(5'd2);
    send_seed(32'h0000_0000);
    send_seed(32'h0000_0001);
    send_seed(32'hFFFF_FFFF);
    send_seed($urandom);
    drain_and_settle();

    // Random phases, each with its own count and idling pattern.
    while (seeds_sent < TOTAL_SEEDS) begin
      r = $urandom_range(0, 99);
      if (r < 5) count = 5'd0;
      else if (r < 10) count = 5'd1;
      else if (r < 20) count = 5'd16;
      else if (r < 28) count = 5'($urandom_range(17, 31));
      else count = 5'($urandom_range(2, 15));
      gap_level   = $urandom_range(0, 2);
      ready_level = $urandom_range(0, 2);
      write_count(count);
      phase_items = $urandom_range(8, 25);
      repeat (phase_items) send_seed(random_seed());
      drain_and_settle();
    end

    $display("Run covered %0d seeds and %0d checked permutation entries.",
             seeds_sent, entries_checked);
    $display("Entry count settings exercised (bit per count 0..31): %b", counts_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("xorshift_permutation_generator_top regression: pass");
    end else begin
      $display("%0d failures, %0d entries still outstanding", mismatches, outstanding);
      $display("xorshift_permutation_generator_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/xpg_pkg.sv
rtl/core/xpg_modulo.sv
rtl/core/xpg_table.sv
rtl/core/xorshift_permutation_generator_top.sv
tb/shuffle_checker.sv
tb/tb_xorshift_permutation_generator_top.sv
